[sv/kvt_pkg.sv]
// Package for the key velocity tracker: sizes, codes, the sequencer state type
// and the structs passed between the core and its per-key store.
// No dependencies.
package kvt_pkg;

    localparam int KVT_KEY_COUNT    = 192;
    localparam int KVT_READING_BITS = 16;

    localparam int KVT_KEY_W     = (KVT_KEY_COUNT > 1) ? $clog2(KVT_KEY_COUNT) : 1;
    localparam int KVT_KEY_CMP_W = 11;
    localparam int KVT_RB        = KVT_READING_BITS;
    localparam int KVT_MUL_W     = KVT_RB + 2;
    localparam int KVT_PROD_W    = 2 * KVT_MUL_W;
    localparam int KVT_REM_W     = 2 * KVT_RB + 2;
    localparam int KVT_THR_W     = 10;
    localparam int KVT_NOTE_W    = 7;
    localparam int KVT_VEL_W     = 7;
    localparam int KVT_CNT_W     = $clog2(KVT_VEL_W + 1);
    localparam int KVT_CFG_IDX_W = 4;
    localparam int KVT_PERMILLE  = 1000;

    localparam logic [KVT_THR_W-1:0] KVT_LOW_THR_RESET  = KVT_THR_W'(100);
    localparam logic [KVT_THR_W-1:0] KVT_HIGH_THR_RESET = KVT_THR_W'(900);

    localparam logic [KVT_CFG_IDX_W-1:0] KVT_CFG_LOW_THR  = KVT_CFG_IDX_W'(0);
    localparam logic [KVT_CFG_IDX_W-1:0] KVT_CFG_HIGH_THR = KVT_CFG_IDX_W'(1);

    localparam logic KVT_CMD_SAMPLE = 1'b0;
    localparam logic KVT_CMD_LOAD   = 1'b1;

    localparam logic KVT_EV_NOTE_ON  = 1'b0;
    localparam logic KVT_EV_NOTE_OFF = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_DISP,
        ST_MUL_LOW,
        ST_MUL_HIGH,
        ST_DECIDE,
        ST_MUL_VEL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT
    } kvt_state_t;

    typedef struct packed {
        logic                  we;
        logic [KVT_KEY_W-1:0]  addr;
        logic [KVT_RB-1:0]     low;
        logic [KVT_RB-1:0]     high;
        logic [KVT_NOTE_W-1:0] note;
    } kvt_cal_wr_t;

    typedef struct packed {
        logic                 we;
        logic [KVT_KEY_W-1:0] addr;
        logic [KVT_RB-1:0]    prev;
        logic [KVT_RB:0]      peak;
        logic                 releasing;
    } kvt_trk_wr_t;

    typedef struct packed {
        logic [KVT_RB-1:0]     prev;
        logic [KVT_RB:0]       peak;
        logic                  releasing;
        logic [KVT_RB-1:0]     low;
        logic [KVT_RB-1:0]     high;
        logic [KVT_NOTE_W-1:0] note;
    } kvt_key_rd_t;

endpackage

[sv/kvt_key_store.sv]
// Per-key storage: calibration memory, tracking memory (last reading, peak and
// release flag) and the valid bits of the tracking entries. Depends on kvt_pkg.
module kvt_key_store (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [kvt_pkg::KVT_KEY_W-1:0] rd_addr,
    input  kvt_pkg::kvt_cal_wr_t     cal_wr,
    input  kvt_pkg::kvt_trk_wr_t     trk_wr,
    output kvt_pkg::kvt_key_rd_t     rd
);
    import kvt_pkg::*;

    localparam int CAL_W = 2 * KVT_RB + KVT_NOTE_W;
    localparam int TRK_W = 2 * KVT_RB + 2;

    logic [CAL_W-1:0] cal_mem [KVT_KEY_COUNT];
    logic [TRK_W-1:0] trk_mem [KVT_KEY_COUNT];
    logic [KVT_KEY_COUNT-1:0] trk_valid_reg;

    logic [CAL_W-1:0] cal_q_reg;
    logic [TRK_W-1:0] trk_q_reg;
    logic             trk_v_reg;

    always_ff @(posedge aclk) begin
        if (cal_wr.we) begin
            cal_mem[cal_wr.addr] <= {cal_wr.low, cal_wr.high, cal_wr.note};
        end
        if (rd_en) begin
            cal_q_reg <= cal_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (trk_wr.we) begin
            trk_mem[trk_wr.addr] <= {trk_wr.prev, trk_wr.peak, trk_wr.releasing};
        end
        if (rd_en) begin
            trk_q_reg <= trk_mem[rd_addr];
        end
    end

    // Entries never written since reset read as zero through their valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_valid_reg <= '0;
            trk_v_reg     <= 1'b0;
        end else begin
            if (trk_wr.we) begin
                trk_valid_reg[trk_wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                trk_v_reg <= trk_valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        rd.low       = cal_q_reg[CAL_W-1 -: KVT_RB];
        rd.high      = cal_q_reg[KVT_RB+KVT_NOTE_W-1 -: KVT_RB];
        rd.note      = cal_q_reg[KVT_NOTE_W-1:0];
        rd.prev      = trk_v_reg ? trk_q_reg[TRK_W-1 -: KVT_RB] : '0;
        rd.peak      = trk_v_reg ? trk_q_reg[KVT_RB+1 -: KVT_RB+1] : '0;
        rd.releasing = trk_v_reg ? trk_q_reg[0] : 1'b0;
    end

endmodule

[sv/key_velocity_tracker_core.sv]
// Top level of the key velocity tracker: stream ports, configuration port and
// the sequencer around one shared multiplier and a bit-per-cycle divider.
// Depends on kvt_pkg and kvt_key_store.
//
// Each input item either loads a key's calibration (min, max, note) or delivers
// one sensor sample for a key. A load item is written in the idle state and gives no result.
// A sample item keeps the block busy, taking no new item, through the fetch, the
// threshold multiplies and the decision, and then through the emit step when it
// gives an event; a note-on with a nonzero velocity first goes through the velocity
// multiply and the division. The steps are those of the
// single shared multiplier, which forms the three threshold products and the
// velocity product one per cycle, and of the restoring divider, which resolves
// the clamp test and then one velocity bit per cycle. Items whose key index is
// not below the key count are taken and ignored. A finished event
// sits in an output register, so the block goes on with the next item while it
// waits to be taken; when the next event is ready while that register is still
// occupied, the block holds in its emit step until the register frees up.
// No clearing pass is needed after reset; tracking state of
// keys not yet sampled reads as zero through valid bits.
module key_velocity_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: key_index[7:0], reading[15:0], cal_min[15:0],
    // cal_max[15:0], note_number[6:0], one zero pad bit.
    input  logic [63:0] s_tdata,
    // s_tuser: command (0 sensor sample, 1 load calibration).
    input  logic        s_tuser,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: event_note[6:0], event_velocity[6:0], two zero pad bits.
    output logic [15:0] m_tdata,
    // m_tuser: event_kind (0 note on, 1 note off).
    output logic        m_tuser,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [kvt_pkg::KVT_CFG_IDX_W-1:0] cfg_index,
    input  logic [kvt_pkg::KVT_THR_W-1:0]     cfg_data
);
    import kvt_pkg::*;

    localparam int RB = KVT_RB;

    // Unpacked input fields.
    logic [7:0]            in_key;
    logic [15:0]           in_reading;
    logic [15:0]           in_cal_min;
    logic [15:0]           in_cal_max;
    logic [KVT_NOTE_W-1:0] in_note;

    assign in_key     = s_tdata[7:0];
    assign in_reading = s_tdata[23:8];
    assign in_cal_min = s_tdata[39:24];
    assign in_cal_max = s_tdata[55:40];
    assign in_note    = s_tdata[62:56];

    // Control state.
    kvt_state_t            state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [KVT_THR_W-1:0]  low_thr_reg, low_thr_next;
    logic [KVT_THR_W-1:0]  high_thr_reg, high_thr_next;

    // Datapath registers for the item at work.
    logic [KVT_KEY_W-1:0]         key_reg, key_next;
    logic [RB-1:0]                reading_reg, reading_next;
    logic [KVT_NOTE_W-1:0]        note_reg, note_next;
    logic signed [KVT_MUL_W-1:0]  n_reg, n_next;
    logic [RB-1:0]                s_reg, s_next;
    logic signed [RB:0]           vel_reg, vel_next;
    logic signed [RB:0]           peak_old_reg, peak_old_next;
    logic                         rel_old_reg, rel_old_next;
    logic signed [RB:0]           peak_reg, peak_next;
    logic signed [KVT_PROD_W-1:0] nk_reg, nk_next;
    logic                         above_lo_reg, above_lo_next;
    logic                         below_lo_reg, below_lo_next;
    logic signed [KVT_PROD_W-1:0] prod_reg;
    logic [KVT_REM_W-1:0]         rem_reg, rem_next;
    logic [KVT_VEL_W-1:0]         quo_reg, quo_next;
    logic [KVT_CNT_W-1:0]         cnt_reg, cnt_next;
    logic                         ev_kind_reg, ev_kind_next;
    logic [KVT_VEL_W-1:0]         ev_vel_reg, ev_vel_next;
    logic                         m_kind_reg, m_kind_next;
    logic [KVT_NOTE_W-1:0]        m_note_reg, m_note_next;
    logic [KVT_VEL_W-1:0]         m_vel_reg, m_vel_next;

    // Shared multiplier operands; the product is registered every cycle.
    logic signed [KVT_MUL_W-1:0]  mul_a, mul_b;
    logic signed [KVT_PROD_W-1:0] mul_p;

    // Store interface.
    logic                 rd_en;
    kvt_cal_wr_t          cal_wr;
    kvt_trk_wr_t          trk_wr;
    kvt_key_rd_t          rd;

    kvt_key_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (KVT_KEY_W'(in_key)),
        .cal_wr  (cal_wr),
        .trk_wr  (trk_wr),
        .rd      (rd)
    );

    assign mul_p = mul_a * mul_b;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tdata   = {2'b00, m_vel_reg, m_note_reg};

    // Scratch values of the sequencer.
    logic                         in_range;
    logic signed [KVT_MUL_W-1:0]  r_s, prev_s, lo_s, hi_s, num_s, span_s, neg_span;
    logic signed [KVT_MUL_W-1:0]  vel_full;
    logic                         above_hi;
    logic signed [RB:0]           peak_sel;
    logic                         note_on;
    logic [KVT_REM_W-1:0]         cand;
    logic                         ge;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        low_thr_next  = low_thr_reg;
        high_thr_next = high_thr_reg;
        key_next      = key_reg;
        reading_next  = reading_reg;
        note_next     = note_reg;
        n_next        = n_reg;
        s_next        = s_reg;
        vel_next      = vel_reg;
        peak_old_next = peak_old_reg;
        rel_old_next  = rel_old_reg;
        peak_next     = peak_reg;
        nk_next       = nk_reg;
        above_lo_next = above_lo_reg;
        below_lo_next = below_lo_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        ev_kind_next  = ev_kind_reg;
        ev_vel_next   = ev_vel_reg;
        m_kind_next   = m_kind_reg;
        m_note_next   = m_note_reg;
        m_vel_next    = m_vel_reg;

        mul_a = n_reg;
        mul_b = '0;
        rd_en = 1'b0;

        cal_wr.we   = 1'b0;
        cal_wr.addr = KVT_KEY_W'(in_key);
        cal_wr.low  = RB'(in_cal_min);
        cal_wr.high = RB'(in_cal_max);
        cal_wr.note = in_note;

        trk_wr.we        = 1'b0;
        trk_wr.addr      = key_reg;
        trk_wr.prev      = reading_reg;
        trk_wr.peak      = peak_old_reg;
        trk_wr.releasing = rel_old_reg;

        in_range = (KVT_KEY_CMP_W'(in_key) < KVT_KEY_CMP_W'(KVT_KEY_COUNT));
        r_s      = signed'({2'b00, reading_reg});
        prev_s   = signed'({2'b00, rd.prev});
        lo_s     = signed'({2'b00, rd.low});
        hi_s     = signed'({2'b00, rd.high});
        vel_full = r_s - prev_s;
        num_s    = r_s - lo_s;
        span_s   = hi_s - lo_s;
        neg_span = -span_s;
        above_hi = (s_reg != '0) && (nk_reg > prod_reg);
        peak_sel = (above_lo_reg && (vel_reg > peak_old_reg)) ? vel_reg : peak_old_reg;
        note_on  = above_hi || ((vel_reg <= 0) && (peak_sel > 0));
        cand     = KVT_REM_W'({s_reg, 1'b0}) << cnt_reg;
        ge       = (rem_reg >= cand);

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                KVT_CFG_LOW_THR:  low_thr_next  = cfg_data;
                KVT_CFG_HIGH_THR: high_thr_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_range) begin
                    if (s_tuser == KVT_CMD_LOAD) begin
                        cal_wr.we = 1'b1;
                    end else begin
                        rd_en        = 1'b1;
                        key_next     = KVT_KEY_W'(in_key);
                        reading_next = RB'(in_reading);
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // Normalize the span to be non-negative; the numerator follows its sign.
                vel_next      = vel_full[RB:0];
                s_next        = span_s[KVT_MUL_W-1] ? neg_span[RB-1:0] : span_s[RB-1:0];
                n_next        = span_s[KVT_MUL_W-1] ? -num_s : num_s;
                peak_old_next = signed'(rd.peak);
                rel_old_next  = rd.releasing;
                note_next     = rd.note;
                state_next    = ST_MUL_DISP;
            end
            ST_MUL_DISP: begin
                mul_a      = n_reg;
                mul_b      = KVT_MUL_W'(KVT_PERMILLE);
                state_next = ST_MUL_LOW;
            end
            ST_MUL_LOW: begin
                nk_next    = prod_reg;
                mul_a      = signed'(KVT_MUL_W'(low_thr_reg));
                mul_b      = signed'({2'b00, s_reg});
                state_next = ST_MUL_HIGH;
            end
            ST_MUL_HIGH: begin
                // The product now holds low threshold times span.
                above_lo_next = (s_reg != '0) && (nk_reg > prod_reg);
                below_lo_next = (s_reg == '0) ? (low_thr_reg != '0) : (nk_reg < prod_reg);
                mul_a         = signed'(KVT_MUL_W'(high_thr_reg));
                mul_b         = signed'({2'b00, s_reg});
                state_next    = ST_DECIDE;
            end
            ST_DECIDE: begin
                trk_wr.we = 1'b1;
                if (!rel_old_reg) begin
                    if (note_on) begin
                        trk_wr.peak      = '0;
                        trk_wr.releasing = 1'b1;
                        ev_kind_next     = KVT_EV_NOTE_ON;
                        if ((s_reg != '0) && (n_reg > 0) && (peak_sel > 0)) begin
                            peak_next  = peak_sel;
                            state_next = ST_MUL_VEL;
                        end else begin
                            ev_vel_next = '0;
                            state_next  = ST_EMIT;
                        end
                    end else begin
                        trk_wr.peak = peak_sel;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    if (below_lo_reg) begin
                        trk_wr.peak      = '0;
                        trk_wr.releasing = 1'b0;
                        ev_kind_next     = KVT_EV_NOTE_OFF;
                        ev_vel_next      = '0;
                        state_next       = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL_VEL: begin
                mul_a      = n_reg;
                mul_b      = signed'({peak_reg[RB], peak_reg});
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                // Rounded quotient: (2 * product + span) / (2 * span).
                rem_next   = KVT_REM_W'({prod_reg[2*RB-1:0], 1'b0}) + KVT_REM_W'(s_reg);
                quo_next   = '0;
                cnt_next   = KVT_CNT_W'(KVT_VEL_W);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - cand;
                end
                if (cnt_reg == KVT_CNT_W'(KVT_VEL_W)) begin
                    // A quotient of 128 or more clamps to the top velocity.
                    if (ge) begin
                        ev_vel_next = {KVT_VEL_W{1'b1}};
                        state_next  = ST_EMIT;
                    end
                end else begin
                    quo_next[cnt_reg[KVT_CNT_W-1:0]] = ge;
                    if (cnt_reg == '0) begin
                        ev_vel_next = quo_reg | KVT_VEL_W'(ge);
                        state_next  = ST_EMIT;
                    end
                end
                cnt_next = cnt_reg - KVT_CNT_W'(1);
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = ev_kind_reg;
                    m_note_next  = note_reg;
                    m_vel_next   = ev_vel_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            low_thr_reg  <= KVT_LOW_THR_RESET;
            high_thr_reg <= KVT_HIGH_THR_RESET;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            low_thr_reg  <= low_thr_next;
            high_thr_reg <= high_thr_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        reading_reg  <= reading_next;
        note_reg     <= note_next;
        n_reg        <= n_next;
        s_reg        <= s_next;
        vel_reg      <= vel_next;
        peak_old_reg <= peak_old_next;
        rel_old_reg  <= rel_old_next;
        peak_reg     <= peak_next;
        nk_reg       <= nk_next;
        above_lo_reg <= above_lo_next;
        below_lo_reg <= below_lo_next;
        prod_reg     <= mul_p;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        ev_kind_reg  <= ev_kind_next;
        ev_vel_reg   <= ev_vel_next;
        m_kind_reg   <= m_kind_next;
        m_note_reg   <= m_note_next;
        m_vel_reg    <= m_vel_next;
    end

endmodule
